// ----- sv/dttf_pkg.sv -----
// Shared types, constants and constant tables for the decimal text to fixed point block.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package dttf_pkg;

  // Number format
  localparam int FRAC_BITS       = 32;
  localparam int MANTISSA_DIGITS = 18;

  // Parser state widths and limits
  localparam int MANT_W     = 60;
  localparam int EV_W       = 10;
  localparam int FRAC_CNT_W = 5;
  localparam int DROP_W     = 6;
  localparam int E_W        = 12;
  localparam int EV_MAX     = 999;
  localparam int FRAC_MAX   = 31;
  localparam int DROP_MAX   = 63;

  // Character codes
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Scaling unit sizes: the dividend is the mantissa shifted up by FRAC_BITS,
  // and the power-of-ten table reaches one entry past the largest dividend.
  localparam int DVD_W   = MANT_W + FRAC_BITS;
  localparam int POW10_N = DVD_W * 31 / 100 + 2;
  localparam int K_W     = $clog2(POW10_N);
  localparam int DIV_W   = 4 * POW10_N;
  localparam int BIT_W   = $clog2(DVD_W + 1);
  localparam int QX_W    = DVD_W + 64;

  // Clamp values and the bounds used while scaling up
  localparam logic [63:0] LIM_POS    = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] LIM_NEG    = 64'h8000_0000_0000_0000;
  localparam logic [63:0] LIMD10_POS = LIM_POS / 10;
  localparam logic [63:0] LIMD10_NEG = LIM_NEG / 10;
  localparam logic [63:0] LIMSH_POS  = LIM_POS >> FRAC_BITS;
  localparam logic [63:0] LIMSH_NEG  = LIM_NEG >> FRAC_BITS;

  // Job queue between parser and scaler
  localparam int QUEUE_DEPTH = 2;
  localparam int QP_W        = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    PH_SIGN,
    PH_INT,
    PH_FRAC,
    PH_ESIGN,
    PH_EXP,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_UP,
    BK_DOWN,
    BK_CHECK,
    BK_FIN
  } back_state_t;

  // One parsed number waiting for scaling
  typedef struct packed {
    logic                  neg;
    logic [MANT_W-1:0]     mant;
    logic signed [E_W-1:0] e;
  } job_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } q_stat_t;

  typedef logic [DIV_W-1:0] pow10_tab_t [POW10_N];

  function automatic logic [MANT_W-1:0] keep_limit_f(input int digits);
    logic [MANT_W-1:0] p;
    p = MANT_W'(1);
    for (int i = 1; i < digits; i++) begin
      p = p * MANT_W'(10);
    end
    return p;
  endfunction

  function automatic pow10_tab_t gen_pow10();
    pow10_tab_t        t;
    logic [DIV_W-1:0]  p;
    p = DIV_W'(1);
    for (int i = 0; i < POW10_N; i++) begin
      t[i] = p;
      p    = p * DIV_W'(10);
    end
    return t;
  endfunction

  localparam logic [MANT_W-1:0] KEEP_LIMIT = keep_limit_f(MANTISSA_DIGITS);
  localparam pow10_tab_t        POW10      = gen_pow10();

endpackage

`default_nettype wire

// ----- sv/decimal_text_to_fixed_point_top.sv -----
// Decimal text to signed Q32.32: one character per input beat, one result per string.
// A character is parsed in the cycle it is accepted. After the last character, a zero
// mantissa goes to the output register unscaled; otherwise the value is scaled up by one
// multiply by ten per step, stopping early at saturation, or down by one restoring
// division step per dividend bit. Throughput: one character per cycle while the two-entry
// job queue has room. Reset (rst_n low, synchronous) empties the queue and output register.
`default_nettype none

module decimal_text_to_fixed_point_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream of characters
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] char_code
  input  wire logic        in_tlast,   // last character of the string
  // Result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // [63:0] value, signed Q32.32
  output logic [7:0]       out_tuser   // [0] saturated, [7:1] zero
);
  import dttf_pkg::*;

  // The front parser pushes one job per string; the queue lets it keep taking
  // characters of the next string while the back unit is still scaling.
  logic    push;
  job_t    push_job;
  logic    pop;
  job_t    pop_job;
  q_stat_t q_stat;

  dttf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_stat    (q_stat),
    .push      (push),
    .push_job  (push_job)
  );

  dttf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .q_stat   (q_stat)
  );

  // The back unit scales the decimal mantissa and drives the output register,
  // which holds a finished beat while the next job is already being scaled.
  dttf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .job        (pop_job),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

// ----- sv/dttf_front.sv -----
// Character parser: accepts one character per beat and builds sign, mantissa and exponent.
// Depends on dttf_pkg; pushes one job into the queue on the last character.
`default_nettype none

module dttf_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [7:0]       in_tdata,
  input  wire logic             in_tlast,
  input  wire dttf_pkg::q_stat_t q_stat,
  output logic                  push,
  output dttf_pkg::job_t        push_job
);
  import dttf_pkg::*;

  phase_t                  phase_r, phase_nxt, ph_eff;
  logic                    neg_r, neg_nxt;
  logic [MANT_W-1:0]       mant_r, mant_nxt;
  logic [FRAC_CNT_W-1:0]   frac_r, frac_nxt;
  logic [DROP_W-1:0]       drop_r, drop_nxt;
  logic                    eneg_r, eneg_nxt;
  logic [EV_W-1:0]         ev_r, ev_nxt;

  logic                    accept;
  logic                    is_digit;
  logic [3:0]              dig;
  logic [MANT_W-1:0]       mant_x10;
  logic [13:0]             ev_x10;
  logic signed [E_W-1:0]   e_exp;

  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;
  assign is_digit  = (in_tdata >= CH_ZERO) && (in_tdata <= CH_NINE);
  assign dig       = 4'(in_tdata - CH_ZERO);
  assign mant_x10  = (mant_r << 3) + (mant_r << 1) + MANT_W'(dig);
  assign ev_x10    = (14'(ev_r) << 3) + (14'(ev_r) << 1) + 14'(dig);

  // A sign phase character other than '-' is parsed as an integer character.
  assign ph_eff = (phase_r == PH_SIGN && in_tdata != CH_MINUS) ? PH_INT : phase_r;

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    unique case (ph_eff)
      PH_SIGN: phase_nxt = PH_INT;
      PH_INT: begin
        if (is_digit) phase_nxt = PH_INT;
        else if (in_tdata == CH_DOT) phase_nxt = PH_FRAC;
        else if (in_tdata == CH_E) phase_nxt = PH_ESIGN;
        else phase_nxt = PH_DONE;
      end
      PH_FRAC: begin
        if (is_digit) phase_nxt = PH_FRAC;
        else if (in_tdata == CH_E) phase_nxt = PH_ESIGN;
        else phase_nxt = PH_DONE;
      end
      PH_ESIGN: begin
        if (in_tdata == CH_PLUS || in_tdata == CH_MINUS) phase_nxt = PH_EXP;
        else phase_nxt = PH_DONE;
      end
      PH_EXP: phase_nxt = is_digit ? PH_EXP : PH_DONE;
      default: phase_nxt = PH_DONE;
    endcase
  end

  // Number fields after this character
  always_comb begin
    neg_nxt  = neg_r;
    mant_nxt = mant_r;
    frac_nxt = frac_r;
    drop_nxt = drop_r;
    eneg_nxt = eneg_r;
    ev_nxt   = ev_r;
    unique case (ph_eff)
      PH_SIGN: neg_nxt = 1'b1;
      PH_INT: begin
        if (is_digit) begin
          if (mant_r < KEEP_LIMIT) mant_nxt = mant_x10;
          else if (drop_r < DROP_W'(DROP_MAX)) drop_nxt = drop_r + DROP_W'(1);
        end
      end
      PH_FRAC: begin
        if (is_digit && mant_r < KEEP_LIMIT && frac_r < FRAC_CNT_W'(FRAC_MAX)) begin
          mant_nxt = mant_x10;
          frac_nxt = frac_r + FRAC_CNT_W'(1);
        end
      end
      PH_ESIGN: begin
        if (in_tdata == CH_PLUS) eneg_nxt = 1'b0;
        else if (in_tdata == CH_MINUS) eneg_nxt = 1'b1;
      end
      PH_EXP: begin
        if (is_digit) begin
          ev_nxt = (ev_x10 > 14'(EV_MAX)) ? EV_W'(EV_MAX) : ev_x10[EV_W-1:0];
        end
      end
      default: ;
    endcase
  end

  assign e_exp = eneg_nxt ? -E_W'(ev_nxt) : E_W'(ev_nxt);

  always_comb begin
    push          = accept && in_tlast;
    push_job.neg  = neg_nxt;
    push_job.mant = mant_nxt;
    push_job.e    = e_exp + E_W'(drop_nxt) - E_W'(frac_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SIGN;
      neg_r   <= 1'b0;
      mant_r  <= '0;
      frac_r  <= '0;
      drop_r  <= '0;
      eneg_r  <= 1'b0;
      ev_r    <= '0;
    end else if (accept) begin
      if (in_tlast) begin
        phase_r <= PH_SIGN;
        neg_r   <= 1'b0;
        mant_r  <= '0;
        frac_r  <= '0;
        drop_r  <= '0;
        eneg_r  <= 1'b0;
        ev_r    <= '0;
      end else begin
        phase_r <= phase_nxt;
        neg_r   <= neg_nxt;
        mant_r  <= mant_nxt;
        frac_r  <= frac_nxt;
        drop_r  <= drop_nxt;
        eneg_r  <= eneg_nxt;
        ev_r    <= ev_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/dttf_queue.sv -----
// Short job queue that decouples the character parser from the scaling unit.
// Depends on dttf_pkg for the job type and depth.
`default_nettype none

module dttf_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire dttf_pkg::job_t    push_job,
  input  wire logic              pop,
  output dttf_pkg::job_t         pop_job,
  output dttf_pkg::q_stat_t      q_stat
);
  import dttf_pkg::*;

  job_t            ent_r [QUEUE_DEPTH];
  logic [QP_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QP_W:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign q_stat.not_empty = (cnt_r != '0);
  assign q_stat.full      = (cnt_r == (QP_W+1)'(QUEUE_DEPTH));
  assign do_push          = push && !q_stat.full;
  assign do_pop           = pop && q_stat.not_empty;
  assign pop_job          = ent_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + (QP_W+1)'(1);
    else if (do_pop && !do_push) cnt_nxt = cnt_r - (QP_W+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) ent_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + QP_W'(1);
      if (do_pop) rd_ptr_r <= rd_ptr_r + QP_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/dttf_back.sv -----
// Scaling unit: turns a parsed mantissa and decimal exponent into saturated Q32.32.
// Depends on dttf_pkg; scales up by one multiply by ten per cycle, down by one restoring
// division step per cycle, and holds the result in an output register.
`default_nettype none

module dttf_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dttf_pkg::q_stat_t q_stat,
  input  wire dttf_pkg::job_t    job,
  output logic                   pop,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [63:0]            out_tdata,
  output logic [7:0]             out_tuser
);
  import dttf_pkg::*;

  back_state_t       st_r, st_nxt;
  logic              neg_r, neg_nxt;
  logic [63:0]       m_r, m_nxt;
  logic [E_W-2:0]    cnt_r, cnt_nxt;
  logic [DVD_W-1:0]  dvd_r, dvd_nxt;
  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [DIV_W-1:0]  div_r, div_nxt;
  logic [BIT_W-1:0]  bit_r, bit_nxt;
  logic [63:0]       mag_r, mag_nxt;
  logic              sat_r, sat_nxt;
  logic              ov_r, ov_nxt;
  logic [63:0]       od_r, od_nxt;
  logic              os_r, os_nxt;

  logic              fin_fire;
  logic [63:0]       lim, lim_d10, lim_sh;
  logic              up_ovf;
  logic [DIV_W:0]    rem_sh;
  logic              ge;
  logic [E_W-1:0]    neg_e;
  logic [K_W-1:0]    kidx;
  logic [QX_W-1:0]   q_ext, lim_ext;

  assign lim     = neg_r ? LIM_NEG : LIM_POS;
  assign lim_d10 = neg_r ? LIMD10_NEG : LIMD10_POS;
  assign lim_sh  = neg_r ? LIMSH_NEG : LIMSH_POS;
  assign up_ovf  = m_r > lim_d10;
  assign rem_sh  = {rem_r, dvd_r[DVD_W-1]};
  assign ge      = rem_sh >= {1'b0, div_r};
  assign neg_e   = -job.e;
  assign kidx    = (neg_e > E_W'(POW10_N - 1)) ? K_W'(POW10_N - 1) : neg_e[K_W-1:0];
  assign q_ext   = QX_W'(dvd_r);
  assign lim_ext = QX_W'(lim);
  assign fin_fire = (st_r == BK_FIN) && (!ov_r || out_tready);

  // Next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      BK_IDLE: begin
        if (q_stat.not_empty) begin
          if (job.mant == '0) st_nxt = BK_FIN;
          else if (job.e[E_W-1]) st_nxt = BK_DOWN;
          else st_nxt = BK_UP;
        end
      end
      BK_UP:    if (cnt_r == '0 || up_ovf) st_nxt = BK_FIN;
      BK_DOWN:  if (bit_r == BIT_W'(1)) st_nxt = BK_CHECK;
      BK_CHECK: st_nxt = BK_FIN;
      BK_FIN:   if (fin_fire) st_nxt = BK_IDLE;
      default:  st_nxt = BK_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    pop     = 1'b0;
    neg_nxt = neg_r;
    m_nxt   = m_r;
    cnt_nxt = cnt_r;
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    div_nxt = div_r;
    bit_nxt = bit_r;
    mag_nxt = mag_r;
    sat_nxt = sat_r;
    unique case (st_r)
      BK_IDLE: begin
        if (q_stat.not_empty) begin
          pop     = 1'b1;
          neg_nxt = job.neg;
          m_nxt   = 64'(job.mant);
          cnt_nxt = job.e[E_W-2:0];
          dvd_nxt = DVD_W'(job.mant) << FRAC_BITS;
          rem_nxt = '0;
          div_nxt = POW10[kidx];
          bit_nxt = BIT_W'(DVD_W);
          mag_nxt = '0;
          sat_nxt = 1'b0;
        end
      end
      BK_UP: begin
        if (cnt_r == '0) begin
          sat_nxt = m_r > lim_sh;
          mag_nxt = (m_r > lim_sh) ? lim : (m_r << FRAC_BITS);
        end else if (up_ovf) begin
          sat_nxt = 1'b1;
          mag_nxt = lim;
        end else begin
          m_nxt   = (m_r << 3) + (m_r << 1);
          cnt_nxt = cnt_r - (E_W-1)'(1);
        end
      end
      BK_DOWN: begin
        rem_nxt = ge ? DIV_W'(rem_sh - {1'b0, div_r}) : DIV_W'(rem_sh);
        dvd_nxt = {dvd_r[DVD_W-2:0], ge};
        bit_nxt = bit_r - BIT_W'(1);
      end
      BK_CHECK: begin
        sat_nxt = q_ext > lim_ext;
        mag_nxt = (q_ext > lim_ext) ? lim : 64'(q_ext);
      end
      BK_FIN: ;
      default: ;
    endcase
  end

  // Output register: loads a finished result, clears when the beat is taken.
  always_comb begin
    ov_nxt = ov_r;
    od_nxt = od_r;
    os_nxt = os_r;
    if (fin_fire) begin
      ov_nxt = 1'b1;
      od_nxt = neg_r ? (64'd0 - mag_r) : mag_r;
      os_nxt = sat_r;
    end else if (out_tready) begin
      ov_nxt = 1'b0;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = {7'd0, os_r};

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    m_r   <= m_nxt;
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    bit_r <= bit_nxt;
    mag_r <= mag_nxt;
    sat_r <= sat_nxt;
    od_r  <= od_nxt;
    os_r  <= os_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- test/decimal_text_to_fixed_point_top_test.sv -----
// Self-checking bench for decimal_text_to_fixed_point_top: text strings in, Q32.32 values out.
// Needs dttf_pkg and the top module; predicts each number from the characters it accepts.
`timescale 1ns / 1ps

module decimal_text_to_fixed_point_top_test;
  import dttf_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 150;
  localparam int RANDOM_CHARS   = 340;
  localparam logic [63:0] KEEP_BELOW = 64'd100000000000000000;  // 10^17
  localparam logic [63:0] POS_CLAMP  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_CLAMP  = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_beat_t;

  typedef struct packed {
    logic [63:0] value;
    logic        clamped;
  } fixed_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [7:0]  out_tuser;

  decimal_text_to_fixed_point_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #4 clk = ~clk;

  text_beat_t    text_beats[$];      // characters still to be sent
  fixed_result_t pending_numbers[$]; // predicted results not yet seen

  int mismatches   = 0;
  int strings_sent = 0;
  int chars_taken  = 0;
  int results_seen = 0;
  int clamps_seen  = 0;
  int idle_cycles  = 0;

  // Parser state of the predictor.
  phase_t      parse_phase = PH_SIGN;
  logic        num_negative = 1'b0;
  logic [63:0] digits_kept = '0;
  int          frac_digits = 0;
  int          dropped_digits = 0;
  logic        exp_negative = 1'b0;
  int          exp_magnitude = 0;

  function automatic void clear_parser();
    parse_phase    = PH_SIGN;
    num_negative   = 1'b0;
    digits_kept    = '0;
    frac_digits    = 0;
    dropped_digits = 0;
    exp_negative   = 1'b0;
    exp_magnitude  = 0;
  endfunction

  function automatic void absorb_char(input logic [7:0] c);
    logic       is_dig;
    logic [3:0] d;
    is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
    d      = 4'(c - CH_ZERO);
    // A leading minus is taken; anything else falls into the integer phase at once.
    if (parse_phase == PH_SIGN) begin
      parse_phase = PH_INT;
      if (c == CH_MINUS) begin
        num_negative = 1'b1;
        return;
      end
    end
    case (parse_phase)
      PH_INT: begin
        if (is_dig) begin
          if (digits_kept < KEEP_BELOW) digits_kept = digits_kept * 10 + 64'(d);
          else if (dropped_digits < 63) dropped_digits++;
        end else if (c == CH_DOT) begin
          parse_phase = PH_FRAC;
        end else if (c == CH_E) begin
          parse_phase = PH_ESIGN;
        end else begin
          parse_phase = PH_DONE;
        end
      end
      PH_FRAC: begin
        if (is_dig) begin
          // Fraction digits past the kept precision just truncate.
          if (digits_kept < KEEP_BELOW && frac_digits < 31) begin
            digits_kept = digits_kept * 10 + 64'(d);
            frac_digits++;
          end
        end else if (c == CH_E) begin
          parse_phase = PH_ESIGN;
        end else begin
          parse_phase = PH_DONE;
        end
      end
      PH_ESIGN: begin
        if (c == CH_PLUS) begin
          exp_negative = 1'b0;
          parse_phase  = PH_EXP;
        end else if (c == CH_MINUS) begin
          exp_negative = 1'b1;
          parse_phase  = PH_EXP;
        end else begin
          parse_phase = PH_DONE;
        end
      end
      PH_EXP: begin
        if (is_dig) begin
          exp_magnitude = exp_magnitude * 10 + int'(d);
          if (exp_magnitude > 999) exp_magnitude = 999;
        end else begin
          parse_phase = PH_DONE;
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Scales the kept digits by the net power of ten into Q32.32, clamping on overflow.
  function automatic fixed_result_t settle_number();
    fixed_result_t r;
    logic [63:0]   lim;
    logic [63:0]   m;
    logic [63:0]   mag;
    logic [127:0]  w;
    int            e;
    bit            over;
    lim  = num_negative ? NEG_CLAMP : POS_CLAMP;
    e    = (exp_negative ? -exp_magnitude : exp_magnitude) + dropped_digits - frac_digits;
    m    = digits_kept;
    mag  = '0;
    over = 1'b0;
    if (m != 0) begin
      if (e >= 0) begin
        for (int i = 0; i < e && !over; i++) begin
          if (m > lim / 10) over = 1'b1;
          else m = m * 10;
        end
        if (!over && m > (lim >> 32)) over = 1'b1;
        if (!over) mag = m << 32;
      end else begin
        w = 128'(m) << 32;
        for (int i = 0; i < -e && w != 0; i++) w = w / 128'd10;
        if (w[127:64] != 0 || w[63:0] > lim) over = 1'b1;
        else mag = w[63:0];
      end
    end
    if (over) mag = lim;
    r.value   = num_negative ? -mag : mag;
    r.clamped = over;
    return r;
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
  endfunction

  // An empty string travels as a single NUL beat marked last.
  function automatic void add_text(input string s);
    text_beat_t b;
    strings_sent++;
    if (s.len() == 0) begin
      b.ch   = 8'h00;
      b.last = 1'b1;
      text_beats.push_back(b);
      return;
    end
    for (int i = 0; i < s.len(); i++) begin
      b.ch   = s[i];
      b.last = (i == s.len() - 1);
      text_beats.push_back(b);
    end
  endfunction

  function automatic logic [7:0] rand_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // Mostly well-formed numbers with random digits; some raw noise and broken tails.
  function automatic int add_random_number();
    logic [7:0] t[$];
    text_beat_t b;
    int         n;
    int         sel;
    logic [7:0] c;
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) t.push_back(8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 2) == 0) t.push_back(CH_MINUS);
      sel = $urandom_range(0, 9);
      n   = (sel == 0) ? 0 : (sel == 1) ? $urandom_range(15, 26) : $urandom_range(1, 6);
      for (int i = 0; i < n; i++) t.push_back(rand_digit());
      if ($urandom_range(0, 1) == 1) begin
        t.push_back(CH_DOT);
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 36) : $urandom_range(0, 8);
        for (int i = 0; i < n; i++) t.push_back(rand_digit());
      end
      if ($urandom_range(0, 2) == 0) begin
        t.push_back(CH_E);
        sel = $urandom_range(0, 5);
        if (sel == 0) begin
          c = 8'($urandom_range(0, 255));
          t.push_back((c == CH_PLUS || c == CH_MINUS) ? CH_E : c);
        end else begin
          t.push_back(sel <= 2 ? CH_MINUS : CH_PLUS);
        end
        sel = $urandom_range(0, 7);
        n   = (sel == 0) ? $urandom_range(3, 5) : (sel <= 2) ? 2 : 1;
        for (int i = 0; i < n; i++) t.push_back(rand_digit());
      end
      if ($urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) t.push_back(8'($urandom_range(0, 255)));
      end
      if (t.size() == 0) t.push_back(8'h00);
    end
    strings_sent++;
    foreach (t[i]) begin
      b.ch   = t[i];
      b.last = (i == t.size() - 1);
      text_beats.push_back(b);
    end
    return t.size();
  endfunction

  // Sender: bursts of random length separated by random gaps, some of them zero.
  int            burst_left = 1;
  int            gap_left = 0;
  text_beat_t    next_beat;
  fixed_result_t predicted;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'h00;
      in_tlast  <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        absorb_char(in_tdata);
        chars_taken++;
        if (in_tlast) begin
          predicted = settle_number();
          pending_numbers.push_back(predicted);
          clear_parser();
        end
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0 || text_beats.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_tvalid <= 1'b0;
        end else begin
          next_beat = text_beats.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= next_beat.ch;
          in_tlast  <= next_beat.last;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // Receiver: a rotating ready pattern that is replaced now and then, sometimes by all ones.
  logic [15:0]   ready_pattern = 16'hFFFF;
  int            pattern_age = 0;
  fixed_result_t wanted;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (out_tuser[0]) clamps_seen++;
        if (pending_numbers.size() == 0) begin
          note_mismatch($sformatf("result %h (flags %h) with no number pending",
                                  out_tdata, out_tuser));
        end else begin
          wanted = pending_numbers.pop_front();
          if (out_tdata !== wanted.value)
            note_mismatch($sformatf("value expected %h, got %h", wanted.value, out_tdata));
          if (out_tuser !== {7'b0, wanted.clamped})
            note_mismatch($sformatf("flags expected %h, got %h",
                                    {7'b0, wanted.clamped}, out_tuser));
        end
      end
      if (pattern_age == 0) begin
        pattern_age   = $urandom_range(16, 96);
        ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
      end else begin
        pattern_age--;
      end
      out_tready    <= ready_pattern[0];
      ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
    end
  end

  // Watchdog: too long without any beat on either side means the block is stuck.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no beat for %0d cycles, %0d numbers outstanding",
                 idle_cycles, pending_numbers.size());
        $display("decimal_text_to_fixed_point_top verification failed");
        $finish;
      end
    end
  end

  initial begin
    int random_chars;
    random_chars = 0;

    // Directed strings: empty text, zero forms, rejected plus, exponent forms,
    // range edges, dropped digits, over-long fraction and ignored tails.
    add_text("");
    add_text("0");
    add_text("-0");
    add_text("+5");
    add_text("123.456");
    add_text("-1.5e+3");
    add_text("2e5");
    add_text("1e-3");
    add_text("9e+999");
    add_text("-9e+999");
    add_text("1e-999");
    add_text("1e+99999");
    add_text("2147483647.99999");
    add_text("2147483648");
    add_text("-2147483648");
    add_text("12345678901234567890123");
    add_text("0.00000000000000000000000000000000123");
    add_text("1.5x9e+3");
    add_text("x1");

    while (random_chars < RANDOM_CHARS) random_chars += add_random_number();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (text_beats.size() != 0 || in_tvalid || pending_numbers.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d strings in %0d characters; %0d results checked, %0d of them clamped.",
             strings_sent, chars_taken, results_seen, clamps_seen);
    if (mismatches == 0) begin
      $display("decimal_text_to_fixed_point_top verification clean");
    end else begin
      $display("%0d mismatches in total", mismatches);
      $display("decimal_text_to_fixed_point_top verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/dttf_pkg.sv
sv/dttf_front.sv
sv/dttf_queue.sv
sv/dttf_back.sv
sv/decimal_text_to_fixed_point_top.sv
test/decimal_text_to_fixed_point_top_test.sv
